FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers for the filter top level; compiled out with
// NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define DFIIR_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("dfiir: assertion failed");

`define DFIIR_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("dfiir: forbidden condition seen");

`else

`define DFIIR_ASSERT(lbl, clk, rst, prop)

`define DFIIR_NEVER(lbl, clk, rst, expr)

`endif

`endif

FILE: sv/dfiir_pkg.sv
// ----------------------------------------------------------------------------
// dfiir_pkg
// Shared widths, codes and control types of the direct form I IIR filter.
// ----------------------------------------------------------------------------
package dfiir_pkg;

  localparam int MAX_TAPS_DEF       = 16;
  localparam int COEF_FRAC_BITS_DEF = 14;

  localparam int SAMPLE_W    = 16;
  localparam int COEF_W      = 16;
  localparam int COUNT_W     = 5;
  localparam int INDEX_W     = 4;
  localparam int CFG_INDEX_W = 1;

  // transaction kind
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_COEF   = 1'b1;

  // coefficient bank / history bank
  localparam logic BANK_FWD = 1'b0;
  localparam logic BANK_FB  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_FWD_COUNT = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_FB_COUNT  = 1'b1;

  typedef struct packed {
    logic start;  // clear accumulator, new sample
    logic tap;    // memory read issued this cycle
    logic last;   // final tap of the sample
  } mac_ctrl_t;

endpackage

FILE: sv/dfiir_ctrl.sv
// ----------------------------------------------------------------------------
// dfiir_ctrl
// Sequencer: clearing pass, handshake, tap walk over the circular histories,
// coefficient loads and history write-back.
// ----------------------------------------------------------------------------
module dfiir_ctrl import dfiir_pkg::*; #(
  parameter int MAX_TAPS = MAX_TAPS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  logic                         kind,
  input  logic signed [SAMPLE_W-1:0]   sample_in,
  input  logic                         coef_bank,
  input  logic [INDEX_W-1:0]           coef_index,
  input  logic signed [COEF_W-1:0]     coef_value,
  input  logic                         cfg_we,
  input  logic [CFG_INDEX_W-1:0]       cfg_index,
  input  logic [COUNT_W-1:0]           cfg_data,
  input  logic                         out_free,
  input  logic                         res_valid,
  input  logic signed [SAMPLE_W-1:0]   res_sample,
  output mac_ctrl_t                    mac_ctrl,
  output logic                         finish,
  output logic                         coef_we,
  output logic [$clog2(MAX_TAPS):0]    coef_waddr,
  output logic signed [COEF_W-1:0]     coef_wdata,
  output logic [$clog2(MAX_TAPS):0]    coef_raddr,
  output logic                         hist_we,
  output logic [$clog2(MAX_TAPS):0]    hist_waddr,
  output logic signed [SAMPLE_W-1:0]   hist_wdata,
  output logic [$clog2(MAX_TAPS):0]    hist_raddr
);

  localparam int PTR_W  = $clog2(MAX_TAPS);
  localparam int ADDR_W = PTR_W + 1;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_RUN   = 4'b0100,
    S_WAIT  = 4'b1000
  } state_t;

  state_t              state, state_next;
  logic [ADDR_W-1:0]   clr_cnt;
  logic [COUNT_W-1:0]  fwd_count;
  logic [COUNT_W-1:0]  fb_count;
  logic [PTR_W-1:0]    in_ptr;
  logic [PTR_W-1:0]    out_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [PTR_W-1:0]    tap;
  logic                phase;

  logic                accept, take_sample, take_coef, coef_ok;
  logic                issue, last_issue, clear_done;
  logic [PTR_W-1:0]    fwd_last, fb_last;

  function automatic logic [PTR_W-1:0] eff_last(input logic [COUNT_W-1:0] c);
    logic [PTR_W-1:0] r;
    if (c == '0) begin
      r = '0;
    end else if (int'(c) > MAX_TAPS) begin
      r = PTR_W'(MAX_TAPS - 1);
    end else begin
      r = PTR_W'(c - 1'b1);
    end
    return r;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(MAX_TAPS - 1) : p - 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(MAX_TAPS - 1)) ? '0 : p + 1'b1;
  endfunction

  assign fwd_last    = eff_last(fwd_count);
  assign fb_last     = eff_last(fb_count);

  assign item_stall  = (state != S_IDLE);
  assign accept      = item_valid && (state == S_IDLE);
  assign take_sample = accept && (kind == KIND_SAMPLE);
  assign take_coef   = accept && (kind == KIND_COEF);
  assign coef_ok     = int'(coef_index) < MAX_TAPS;
  assign issue       = (state == S_RUN);
  assign last_issue  = issue && (phase == BANK_FB) && (tap == fb_last);
  assign finish      = (state == S_WAIT) && res_valid && out_free;
  assign clear_done  = (state == S_CLEAR) && (clr_cnt == '1);

  assign mac_ctrl.start = take_sample;
  assign mac_ctrl.tap   = issue;
  assign mac_ctrl.last  = last_issue;

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clear_done) state_next = S_IDLE;
      S_IDLE:  if (take_sample) state_next = S_RUN;
      S_RUN:   if (last_issue) state_next = S_WAIT;
      S_WAIT:  if (finish) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  // memory ports
  assign coef_raddr = {phase, tap};
  assign hist_raddr = {phase, rd_ptr};

  always_comb begin
    coef_we    = 1'b0;
    coef_waddr = clr_cnt;
    coef_wdata = '0;
    if (state == S_CLEAR) begin
      coef_we = 1'b1;
    end else if (take_coef && coef_ok) begin
      coef_we    = 1'b1;
      coef_waddr = {coef_bank, PTR_W'(coef_index)};
      coef_wdata = coef_value;
    end
  end

  always_comb begin
    hist_we    = 1'b0;
    hist_waddr = clr_cnt;
    hist_wdata = '0;
    if (state == S_CLEAR) begin
      hist_we = 1'b1;
    end else if (take_sample) begin
      hist_we    = 1'b1;
      hist_waddr = {BANK_FWD, in_ptr};
      hist_wdata = sample_in;
    end else if (finish) begin
      hist_we    = 1'b1;
      hist_waddr = {BANK_FB, out_ptr};
      hist_wdata = res_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      fwd_count <= COUNT_W'(1);
      fb_count  <= COUNT_W'(1);
      in_ptr    <= '0;
      out_ptr   <= '0;
      rd_ptr    <= '0;
      tap       <= '0;
      phase     <= BANK_FWD;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_FWD_COUNT: fwd_count <= cfg_data;
          REG_FB_COUNT:  fb_count  <= cfg_data;
          default: ;
        endcase
      end
      if (take_sample) begin
        phase  <= BANK_FWD;
        tap    <= '0;
        rd_ptr <= in_ptr;
      end else if (issue) begin
        if ((phase == BANK_FWD) && (tap == fwd_last)) begin
          phase  <= BANK_FB;
          tap    <= '0;
          rd_ptr <= ptr_dec(out_ptr);
        end else begin
          tap    <= tap + 1'b1;
          rd_ptr <= ptr_dec(rd_ptr);
        end
      end
      if (finish) begin
        in_ptr  <= ptr_inc(in_ptr);
        out_ptr <= ptr_inc(out_ptr);
      end
    end
  end

endmodule

FILE: sv/dfiir_mem.sv
// ----------------------------------------------------------------------------
// dfiir_mem
// Coefficient and history stores: one write and one registered read port
// each. Bank bit selects forward or feedback half.
// ----------------------------------------------------------------------------
module dfiir_mem import dfiir_pkg::*; #(
  parameter int MAX_TAPS = MAX_TAPS_DEF
) (
  input  logic                         clk,
  input  logic                         coef_we,
  input  logic [$clog2(MAX_TAPS):0]    coef_waddr,
  input  logic signed [COEF_W-1:0]     coef_wdata,
  input  logic [$clog2(MAX_TAPS):0]    coef_raddr,
  output logic signed [COEF_W-1:0]     coef_rdata,
  input  logic                         hist_we,
  input  logic [$clog2(MAX_TAPS):0]    hist_waddr,
  input  logic signed [SAMPLE_W-1:0]   hist_wdata,
  input  logic [$clog2(MAX_TAPS):0]    hist_raddr,
  output logic signed [SAMPLE_W-1:0]   hist_rdata
);

  localparam int ADDR_W = $clog2(MAX_TAPS) + 1;
  localparam int DEPTH  = 2 ** ADDR_W;

  logic signed [COEF_W-1:0]   coef_ram [DEPTH];
  logic signed [SAMPLE_W-1:0] hist_ram [DEPTH];

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_ram[coef_waddr] <= coef_wdata;
    end
    coef_rdata <= coef_ram[coef_raddr];
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_ram[hist_waddr] <= hist_wdata;
    end
    hist_rdata <= hist_ram[hist_raddr];
  end

endmodule

FILE: sv/dfiir_mac.sv
// ----------------------------------------------------------------------------
// dfiir_mac
// Shared multiply-accumulate, then shift toward zero and 16-bit saturation.
// ----------------------------------------------------------------------------
module dfiir_mac import dfiir_pkg::*; #(
  parameter int MAX_TAPS       = MAX_TAPS_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  mac_ctrl_t                    mac_ctrl,
  input  logic signed [COEF_W-1:0]     coef_rdata,
  input  logic signed [SAMPLE_W-1:0]   hist_rdata,
  output logic                         res_valid,
  output logic signed [SAMPLE_W-1:0]   res_sample,
  output logic                         res_clip
);

  localparam int PROD_W = COEF_W + SAMPLE_W;
  localparam int ACC_W  = PROD_W + $clog2(2 * MAX_TAPS);
  localparam int Q_W    = ACC_W - COEF_FRAC_BITS;

  localparam logic [ACC_W-1:0]      RND   = ACC_W'((64'd1 << COEF_FRAC_BITS) - 64'd1);
  localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(32767);
  localparam logic signed [Q_W-1:0] Q_MIN = Q_W'(-32768);

  logic                      tap1, last1;
  logic                      prod_v, prod_last;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   biased;
  logic signed [Q_W-1:0]     q;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap1      <= 1'b0;
      last1     <= 1'b0;
      prod_v    <= 1'b0;
      prod_last <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      tap1      <= mac_ctrl.tap;
      last1     <= mac_ctrl.last;
      prod_v    <= tap1;
      prod_last <= last1;
      if (mac_ctrl.start) begin
        res_valid <= 1'b0;
      end else if (prod_v && prod_last) begin
        res_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= coef_rdata * hist_rdata;
    if (mac_ctrl.start) begin
      acc <= '0;
    end else if (prod_v) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // truncate toward zero: bias negative sums before the arithmetic shift
  assign biased = acc + (acc[ACC_W-1] ? $signed(RND) : $signed(ACC_W'(0)));
  assign q      = $signed(biased[ACC_W-1:COEF_FRAC_BITS]);

  always_comb begin
    res_clip   = 1'b0;
    res_sample = q[SAMPLE_W-1:0];
    if (q > Q_MAX) begin
      res_clip   = 1'b1;
      res_sample = 16'sh7FFF;
    end else if (q < Q_MIN) begin
      res_clip   = 1'b1;
      res_sample = 16'sh8000;
    end
  end

endmodule

FILE: sv/direct_form_iir_filter_top.sv
// ----------------------------------------------------------------------------
// direct_form_iir_filter_top
// Direct form I IIR filter: 16-bit samples, Q2.14 coefficients, up to
// MAX_TAPS forward and feedback taps through one multiply-accumulate.
// ----------------------------------------------------------------------------
// Input channel (item_valid/item_stall): a transaction with kind = sample
// filters sample_in; kind = coefficient loads coef_value into tap coef_index
// of the bank coef_bank and gives no result.
// Output channel (result_valid/result_stall): sample_out and clipped, one
// transaction per audio sample, in order.
// Config port: cfg_we/cfg_index/cfg_data set the forward and feedback tap
// counts (0 acts as 1, above MAX_TAPS acts as MAX_TAPS); write while idle.
// Timing: the single MAC walks the FN forward and BN feedback taps
// (effective tap counts) one tap per cycle through the history memory
// read port, then through the read, product and sum stages to the result
// register; a new sample is accepted only after the previous result has
// entered the output register. A coefficient load does not stall input.
// Reset: a clearing pass zeroes all entries of both memories, with
// item_stall high meanwhile.
// A stalled result is held in the output register; the next sample is
// accepted meanwhile and waits for the register before its write-back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module direct_form_iir_filter_top import dfiir_pkg::*; #(
  parameter int MAX_TAPS       = MAX_TAPS_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  logic                        kind,
  input  logic signed [SAMPLE_W-1:0]  sample_in,
  input  logic                        coef_bank,
  input  logic [INDEX_W-1:0]          coef_index,
  input  logic signed [COEF_W-1:0]    coef_value,
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic signed [SAMPLE_W-1:0]  sample_out,
  output logic                        clipped,
  input  logic                        cfg_we,
  input  logic [CFG_INDEX_W-1:0]      cfg_index,
  input  logic [COUNT_W-1:0]          cfg_data
);

  localparam int ADDR_W = $clog2(MAX_TAPS) + 1;

  mac_ctrl_t                  mac_ctrl;
  logic                       finish, out_free;
  logic                       res_valid, res_clip;
  logic signed [SAMPLE_W-1:0] res_sample;
  logic                       coef_we, hist_we;
  logic [ADDR_W-1:0]          coef_waddr, coef_raddr, hist_waddr, hist_raddr;
  logic signed [COEF_W-1:0]   coef_wdata, coef_rdata;
  logic signed [SAMPLE_W-1:0] hist_wdata, hist_rdata;

  assign out_free = !result_valid || !result_stall;

  dfiir_ctrl #(
    .MAX_TAPS(MAX_TAPS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .kind       (kind),
    .sample_in  (sample_in),
    .coef_bank  (coef_bank),
    .coef_index (coef_index),
    .coef_value (coef_value),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_free   (out_free),
    .res_valid  (res_valid),
    .res_sample (res_sample),
    .mac_ctrl   (mac_ctrl),
    .finish     (finish),
    .coef_we    (coef_we),
    .coef_waddr (coef_waddr),
    .coef_wdata (coef_wdata),
    .coef_raddr (coef_raddr),
    .hist_we    (hist_we),
    .hist_waddr (hist_waddr),
    .hist_wdata (hist_wdata),
    .hist_raddr (hist_raddr)
  );

  dfiir_mem #(
    .MAX_TAPS(MAX_TAPS)
  ) u_mem (
    .clk        (clk),
    .coef_we    (coef_we),
    .coef_waddr (coef_waddr),
    .coef_wdata (coef_wdata),
    .coef_raddr (coef_raddr),
    .coef_rdata (coef_rdata),
    .hist_we    (hist_we),
    .hist_waddr (hist_waddr),
    .hist_wdata (hist_wdata),
    .hist_raddr (hist_raddr),
    .hist_rdata (hist_rdata)
  );

  dfiir_mac #(
    .MAX_TAPS       (MAX_TAPS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .clk        (clk),
    .rst        (rst),
    .mac_ctrl   (mac_ctrl),
    .coef_rdata (coef_rdata),
    .hist_rdata (hist_rdata),
    .res_valid  (res_valid),
    .res_sample (res_sample),
    .res_clip   (res_clip)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (finish) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      sample_out <= res_sample;
      clipped    <= res_clip;
    end
  end

  `DFIIR_ASSERT(a_finish_into_free_reg, clk, rst, finish |-> (!result_valid || !result_stall))
  `DFIIR_ASSERT(a_busy_after_sample, clk, rst, (item_valid && !item_stall && kind == KIND_SAMPLE) |=> item_stall)
  `DFIIR_ASSERT(a_result_from_finish, clk, rst, $rose(result_valid) |-> $past(finish))
  `DFIIR_NEVER(a_no_tap_when_ready, clk, rst, mac_ctrl.tap && !item_stall)

endmodule

FILE: tb/sv/tb_direct_form_iir_filter_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_direct_form_iir_filter_top
// Self-checking bench for the direct form I IIR filter. A directed table
// covers sample and coefficient extremes, saturation, truncation toward zero
// and ignored fields. Random phases follow under several tap-count settings
// and idle patterns. Each result is compared with the table's expected value
// where the table gives one, else with a local fixed-point filter model.
// ----------------------------------------------------------------------------
module tb_direct_form_iir_filter_top;
  import dfiir_pkg::*;

  localparam int NTAPS = MAX_TAPS_DEF;
  localparam int FRAC = COEF_FRAC_BITS_DEF;
  localparam logic signed [SAMPLE_W-1:0] S_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] S_MIN = 16'sh8000;
  localparam int DIRECTED = 22;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 125;
  localparam int SETTLE_CYCLES = 50;
  localparam int LONG_HOLD = 400;

  typedef struct packed {
    logic                       kind;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       bank;
    logic [INDEX_W-1:0]         idx;
    logic signed [COEF_W-1:0]   value;
    logic                       typed;
    logic signed [SAMPLE_W-1:0] exp_out;
    logic                       exp_clip;
  } stim_row_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       clipped;
  } filt_out_t;

  logic                       clk;
  logic                       rst;
  logic                       item_valid;
  logic                       item_stall;
  logic                       kind;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic                       coef_bank;
  logic [INDEX_W-1:0]         coef_index;
  logic signed [COEF_W-1:0]   coef_value;
  logic                       result_valid;
  logic                       result_stall;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       clipped;
  logic                       cfg_we;
  logic [CFG_INDEX_W-1:0]     cfg_index;
  logic [COUNT_W-1:0]         cfg_data;

  // filter model state
  logic signed [SAMPLE_W-1:0] x_hist [NTAPS];
  logic signed [SAMPLE_W-1:0] y_hist [NTAPS];
  logic signed [COEF_W-1:0]   a_coef [NTAPS];
  logic signed [COEF_W-1:0]   b_coef [NTAPS];
  logic [INDEX_W-1:0]         x_ptr;
  logic [INDEX_W-1:0]         y_ptr;
  logic [COUNT_W-1:0]         a_count;
  logic [COUNT_W-1:0]         b_count;

  filt_out_t expected_outputs [$];
  filt_out_t want;
  stim_row_t directed_rows [DIRECTED];

  int mismatches = 0;
  int results_checked = 0;
  int samples_sent = 0;
  int coef_loads = 0;
  int settings = 0;
  int send_idle_pct = 16;
  int recv_idle_pct = 65;
  int hold_left = 0;

  direct_form_iir_filter_top u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .kind         (kind),
    .sample_in    (sample_in),
    .coef_bank    (coef_bank),
    .coef_index   (coef_index),
    .coef_value   (coef_value),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .sample_out   (sample_out),
    .clipped      (clipped),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("direct_form_iir_filter_top: mismatch");
    $finish;
  end

  function automatic int tap_span(input logic [COUNT_W-1:0] c);
    if (c == 0) return 1;
    if (c > NTAPS) return NTAPS;
    return int'(c);
  endfunction

  function automatic filt_out_t filter_predict(input logic signed [SAMPLE_W-1:0] x);
    longint acc;
    longint q;
    int fn;
    int bn;
    logic [INDEX_W-1:0] slot;
    filt_out_t r;
    fn = tap_span(a_count);
    bn = tap_span(b_count);
    x_hist[x_ptr] = x;
    acc = 0;
    for (int k = 0; k < fn; k++) begin
      slot = x_ptr - INDEX_W'(k);
      acc += longint'(a_coef[k]) * longint'(x_hist[slot]);
    end
    for (int k = 0; k < bn; k++) begin
      slot = y_ptr - INDEX_W'(k + 1);
      acc += longint'(b_coef[k]) * longint'(y_hist[slot]);
    end
    q = acc / (longint'(1) << FRAC);
    r.clipped = 1'b0;
    if (q > 32767) begin
      q = 32767;
      r.clipped = 1'b1;
    end else if (q < -32768) begin
      q = -32768;
      r.clipped = 1'b1;
    end
    r.sample_out = q[SAMPLE_W-1:0];
    y_hist[y_ptr] = r.sample_out;
    x_ptr = x_ptr + 1'b1;
    y_ptr = y_ptr + 1'b1;
    return r;
  endfunction

  // entered just after a falling edge; returns just after a falling edge
  task automatic send_item(input stim_row_t row);
    filt_out_t y;
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    kind       <= row.kind;
    sample_in  <= row.sample;
    coef_bank  <= row.bank;
    coef_index <= row.idx;
    coef_value <= row.value;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    if (row.kind == KIND_COEF) begin
      if (row.bank == BANK_FWD) a_coef[row.idx] = row.value;
      else b_coef[row.idx] = row.value;
      coef_loads++;
    end else begin
      y = filter_predict(row.sample);
      if (row.typed) begin
        y.sample_out = row.exp_out;
        y.clipped    = row.exp_clip;
      end
      expected_outputs.push_back(y);
      samples_sent++;
    end
    @(negedge clk);
  endtask

  task automatic set_tap_counts(input logic [COUNT_W-1:0] fwd, input logic [COUNT_W-1:0] fb);
    item_valid <= 1'b0;
    while (expected_outputs.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FWD_COUNT;
    cfg_data  <= fwd;
    @(negedge clk);
    cfg_index <= REG_FB_COUNT;
    cfg_data  <= fb;
    @(negedge clk);
    cfg_we <= 1'b0;
    a_count = fwd;
    b_count = fb;
    settings++;
  endtask

  initial begin
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        result_stall <= 1'b1;
        hold_left--;
      end else begin
        result_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (expected_outputs.size() == 0) begin
        $error("unexpected result: sample_out=%0d clipped=%0b", sample_out, clipped);
        mismatches++;
      end else begin
        want = expected_outputs.pop_front();
        results_checked++;
        if (sample_out !== want.sample_out) begin
          $error("sample_out: expected %0d, actual %0d", want.sample_out, sample_out);
          mismatches++;
        end
        if (clipped !== want.clipped) begin
          $error("clipped: expected %0b, actual %0b", want.clipped, clipped);
          mismatches++;
        end
      end
    end
  end

  initial begin
    stim_row_t row;
    int shift;
    logic [COUNT_W-1:0] fwd;
    logic [COUNT_W-1:0] fb;

    directed_rows = '{
      '{KIND_SAMPLE, S_MAX, BANK_FWD, 4'd0, 16'sd0, 1'b1, 16'sd0, 1'b0},
      '{KIND_SAMPLE, S_MIN, BANK_FB, 4'd15, S_MAX, 1'b1, 16'sd0, 1'b0},
      '{KIND_COEF, S_MAX, BANK_FWD, 4'd0, 16'sd16384, 1'b0, 16'sd0, 1'b0},
      '{KIND_SAMPLE, S_MAX, BANK_FWD, 4'd0, 16'sd0, 1'b1, S_MAX, 1'b0},
      '{KIND_SAMPLE, S_MIN, BANK_FWD, 4'd0, 16'sd0, 1'b1, S_MIN, 1'b0},
      '{KIND_COEF, 16'sd0, BANK_FWD, 4'd0, S_MAX, 1'b0, 16'sd0, 1'b0},
      '{KIND_SAMPLE, S_MAX, BANK_FWD, 4'd0, 16'sd0, 1'b1, S_MAX, 1'b1},
      '{KIND_SAMPLE, S_MIN, BANK_FWD, 4'd0, 16'sd0, 1'b1, S_MIN, 1'b1},
      '{KIND_COEF, S_MIN, BANK_FWD, 4'd0, S_MIN, 1'b0, 16'sd0, 1'b0},
      '{KIND_SAMPLE, S_MIN, BANK_FWD, 4'd0, 16'sd0, 1'b1, S_MAX, 1'b1},
      '{KIND_SAMPLE, S_MAX, BANK_FWD, 4'd0, 16'sd0, 1'b1, S_MIN, 1'b1},
      '{KIND_COEF, 16'sd0, BANK_FWD, 4'd0, 16'sd1, 1'b0, 16'sd0, 1'b0},
      '{KIND_SAMPLE, 16'sd16385, BANK_FB, 4'd15, -16'sd1, 1'b1, 16'sd1, 1'b0},
      '{KIND_SAMPLE, -16'sd16385, BANK_FWD, 4'd0, 16'sd0, 1'b1, -16'sd1, 1'b0},
      '{KIND_SAMPLE, -16'sd1, BANK_FWD, 4'd0, 16'sd0, 1'b1, 16'sd0, 1'b0},
      '{KIND_COEF, -16'sd1, BANK_FWD, 4'd15, S_MIN, 1'b0, 16'sd0, 1'b0},
      '{KIND_COEF, S_MIN, BANK_FB, 4'd15, S_MAX, 1'b0, 16'sd0, 1'b0},
      '{KIND_COEF, 16'sd0, BANK_FB, 4'd0, -16'sd16384, 1'b0, 16'sd0, 1'b0},
      '{KIND_COEF, 16'sd0, BANK_FWD, 4'd0, 16'sd8192, 1'b0, 16'sd0, 1'b0},
      '{KIND_SAMPLE, 16'sd1000, BANK_FWD, 4'd0, 16'sd0, 1'b0, 16'sd0, 1'b0},
      '{KIND_SAMPLE, S_MIN, BANK_FWD, 4'd0, 16'sd0, 1'b0, 16'sd0, 1'b0},
      '{KIND_SAMPLE, S_MAX, BANK_FWD, 4'd0, 16'sd0, 1'b0, 16'sd0, 1'b0}
    };

    rst        = 1'b1;
    item_valid = 1'b0;
    kind       = KIND_SAMPLE;
    sample_in  = '0;
    coef_bank  = BANK_FWD;
    coef_index = '0;
    coef_value = '0;
    cfg_we     = 1'b0;
    cfg_index  = REG_FWD_COUNT;
    cfg_data   = '0;
    for (int i = 0; i < NTAPS; i++) begin
      x_hist[i] = '0;
      y_hist[i] = '0;
      a_coef[i] = '0;
      b_coef[i] = '0;
    end
    x_ptr   = '0;
    y_ptr   = '0;
    a_count = 5'd1;
    b_count = 5'd1;

    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // settle wait inside also covers the memory clearing pass
    set_tap_counts(5'd1, 5'd1);
    for (int n = 0; n < DIRECTED; n++) send_item(directed_rows[n]);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          fwd = 5'd0;
          fb  = 5'd31;
        end
        1: begin
          fwd = 5'd16;
          fb  = 5'd16;
        end
        3: begin
          fwd = 5'd31;
          fb  = 5'd17;
        end
        default: begin
          fwd = 5'($urandom_range(31));
          fb  = 5'($urandom_range(31));
        end
      endcase
      set_tap_counts(fwd, fb);
      if (ph == 2) begin
        send_idle_pct = 65;
        recv_idle_pct = 16;
      end
      if (ph == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left = LONG_HOLD;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        row.kind = ($urandom_range(99) < 20) ? KIND_COEF : KIND_SAMPLE;
        case ($urandom_range(7))
          0: row.sample = S_MAX;
          1: row.sample = S_MIN;
          2: row.sample = 16'($urandom_range(511)) - 16'sd256;
          default: row.sample = 16'($urandom);
        endcase
        row.bank  = 1'($urandom);
        row.idx   = 4'($urandom);
        shift     = $urandom_range(5);
        row.value = 16'($urandom);
        row.value = row.value >>> shift;
        row.typed    = 1'b0;
        row.exp_out  = '0;
        row.exp_clip = 1'b0;
        send_item(row);
      end
    end

    item_valid <= 1'b0;
    while (expected_outputs.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (expected_outputs.size() != 0) begin
      $error("%0d expected results never arrived", expected_outputs.size());
      mismatches++;
    end

    $display("covered %0d audio samples and %0d coefficient loads, %0d results checked",
             samples_sent, coef_loads, results_checked);
    $display("%0d tap-count settings incl. 0/16/31, three idle patterns, %0d-cycle output hold",
             settings, LONG_HOLD);
    if (mismatches == 0) begin
      $display("direct_form_iir_filter_top: match");
    end else begin
      $display("direct_form_iir_filter_top: mismatch");
    end
    $finish;
  end

endmodule
